[src/flow_segment_stats_table_unit_assert.svh]
// Assertion macros for the flow segment statistics table
`ifndef FLOW_SEGMENT_STATS_TABLE_UNIT_ASSERT_SVH
`define FLOW_SEGMENT_STATS_TABLE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define FSST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FSST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fsst_pkg.sv]
package fsst_pkg;
  localparam int unsigned DefEntries = 16;
  localparam logic [7:0]  DefIdleTtl = 8'd3;

  localparam logic [1:0] FUNC_RECV   = 2'd0;
  localparam logic [1:0] FUNC_DROP   = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_FULL   = 1'b1;

  // One table entry
  typedef struct packed {
    logic [31:0] flow;
    logic [31:0] rcv;
    logic [31:0] drp;
    logic [31:0] ord;
    logic [31:0] msg;
    logic [7:0]  idle;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic        seg;    // apply segment event
    logic        recv;   // received (else dropped)
    logic        app;    // append at the slot flagged by sel_app
    logic [31:0] flow;
    logic [31:0] msg;
    logic        tick;   // walk step: cells take their neighbour value
  } cell_cmd_t;
endpackage

[src/fsst_if.sv]
interface fsst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] flow_id;
  logic [31:0] message_id;
  modport source (output valid, func, flow_id, message_id, input ready);
  modport sink   (input valid, func, flow_id, message_id, output ready);
endinterface

interface fsst_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] report_flow;
  logic [31:0] received_count;
  logic [31:0] dropped_count;
  logic [31:0] reordered_count;
  logic [31:0] last_message;
  logic        last_of_run;
  modport source (output valid, kind, report_flow, received_count, dropped_count,
                  reordered_count, last_message, last_of_run, input ready);
  modport sink   (input valid, kind, report_flow, received_count, dropped_count,
                  reordered_count, last_message, last_of_run, output ready);
endinterface

[src/flow_segment_stats_table_unit.sv]
// Flow segment statistics table. Entries sit in a row of cells, one per
// slot. A received or dropped segment is accepted and then, in ST_SEG,
// every cell compares its flow and the matching (or appended) cell
// updates itself; a full table gives one kind-1 result, and no new request
// is taken until that result has gone. A report tick walks the row: each
// step rotates every cell one place towards slot 0, so the head entry is
// seen, reported and re-entered at the tail cleared or dropped; a tick is
// the accept, one step per entry and a closing step, and a step waits
// while the sink stalls a waiting report; the next request waits until
// the final report has been taken.
// idle_ttl is written through cfg_we.
module flow_segment_stats_table_unit #(
  parameter int unsigned TABLE_ENTRIES = fsst_pkg::DefEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  fsst_in_if.sink     in_ch,
  fsst_out_if.source  out_ch
);
  import fsst_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FullCnt = CW'(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEG  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [7:0]    ttl_r;
  logic [CW-1:0] tot_r, tot_nxt;
  logic [CW-1:0] left_r, left_nxt;   // entries still to visit
  logic [CW-1:0] kept_r, kept_nxt;   // survivors so far
  logic [1:0]    func_r;
  logic [31:0]   flow_r, msg_r;

  logic          ov_r, ov_nxt;
  logic          okind_r, olast_r;
  entry_t        oent_r;
  logic          okind_nxt, olast_nxt;
  entry_t        oent_nxt;

  cell_cmd_t     cmd;
  entry_t        cq  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hits;
  entry_t        head, tail_in;
  logic          head_has, head_keep;
  logic          any_hit;

  assign in_ch.ready = (st_r == ST_IDLE) && !ov_r;
  wire acc = in_ch.valid && in_ch.ready;
  wire out_free = !ov_r || out_ch.ready;

  assign any_hit  = |hits;
  assign head     = cq[0];
  assign head_has = (head.rcv != '0) || (head.drp != '0) || (head.ord != '0)
                    || (head.msg != '0);
  assign head_keep = head_has || (head.idle != ttl_r);

  // Head entry as it re-enters the row
  always_comb begin
    tail_in      = '0;
    tail_in.flow = head.flow;
    tail_in.idle = head_has ? 8'd0 : head.idle + 8'd1;
  end

  wire walk_step = (st_r == ST_WALK) && (left_r != '0) && out_free;

  always_comb begin
    cmd      = '0;
    cmd.seg  = (st_r == ST_SEG) && (func_r != FUNC_TICK);
    cmd.recv = (func_r == FUNC_RECV);
    cmd.flow = flow_r;
    cmd.msg  = msg_r;
    cmd.app  = !any_hit && (tot_r != FullCnt);
    cmd.tick = walk_step;
  end

  // Row of cells; the walk rotates by one, with the head re-entering at
  // slot left+kept-1, just behind the survivors so far
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    entry_t nb;
    logic   lv;
    assign lv = (CW'(g) < tot_r);
    always_comb begin
      if (g == TABLE_ENTRIES - 1) nb = tail_in;
      else if (CW'(g + 1) == left_r + kept_r) nb = tail_in;
      else nb = cq[(g + 1) % TABLE_ENTRIES];
      if (!head_keep && CW'(g + 1) == left_r + kept_r) nb = cq[g];
    end
    fsst_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .sel_app (CW'(g) == tot_r),
      .live    (lv),
      .from_nb (nb),
      .hit     (hits[g]),
      .q       (cq[g])
    );
  end

  // Sequencer and output register
  always_comb begin
    st_nxt    = st_r;
    tot_nxt   = tot_r;
    left_nxt  = left_r;
    kept_nxt  = kept_r;
    ov_nxt    = ov_r && !out_ch.ready;
    okind_nxt = okind_r;
    olast_nxt = olast_r;
    oent_nxt  = oent_r;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.func == FUNC_TICK) begin
            st_nxt   = ST_WALK;
            left_nxt = tot_r;
            kept_nxt = '0;
          end else if (in_ch.func != FUNC_UNUSED) begin
            st_nxt = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        st_nxt = ST_IDLE;
        if (!any_hit) begin
          if (tot_r == FullCnt) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_FULL;
            olast_nxt = 1'b1;
            oent_nxt  = '{flow: flow_r, default: '0};
          end else begin
            tot_nxt = tot_r + CW'(1);
          end
        end
      end
      ST_WALK: begin
        if (left_r == '0) begin
          if (out_free) begin
            st_nxt  = ST_IDLE;
            tot_nxt = kept_r;
            if (ov_r && !olast_r) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
            end
          end
        end else if (out_free) begin
          left_nxt = left_r - CW'(1);
          if (head_keep) begin
            kept_nxt = kept_r + CW'(1);
            // emit previous held result; this one becomes held
            ov_nxt    = 1'b1;
            okind_nxt = KIND_REPORT;
            olast_nxt = 1'b0;
            oent_nxt  = head;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Results are held one step so the final one can be marked; a held
  // report waits in oh_r while ov_r shows the previous one.
  logic   oh_r;
  entry_t oh_ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      tot_r  <= '0;
      left_r <= '0;
      kept_r <= '0;
      ov_r   <= 1'b0;
      oh_r   <= 1'b0;
      ttl_r  <= DefIdleTtl;
    end else begin
      st_r   <= st_nxt;
      tot_r  <= tot_nxt;
      left_r <= left_nxt;
      kept_r <= kept_nxt;
      if (cfg_we) ttl_r <= cfg_wdata;
      if (st_r == ST_WALK && left_r != '0 && out_free && head_keep) begin
        oh_r <= 1'b1;
        ov_r <= oh_r;
      end else if (st_r == ST_WALK && left_r == '0 && out_free) begin
        ov_r <= oh_r;
        oh_r <= 1'b0;
      end else begin
        ov_r <= ov_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      func_r <= in_ch.func;
      flow_r <= in_ch.flow_id;
      msg_r  <= in_ch.message_id;
    end
    if (st_r == ST_WALK && out_free && (left_r != '0 ? head_keep : oh_r)) begin
      oent_r  <= oh_ent_r;
      okind_r <= KIND_REPORT;
      olast_r <= (left_r == '0);
      if (left_r != '0) oh_ent_r <= head;
    end else if (st_r != ST_WALK) begin
      oent_r  <= oent_nxt;
      okind_r <= okind_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.kind            = okind_r;
  assign out_ch.report_flow     = oent_r.flow;
  assign out_ch.received_count  = oent_r.rcv;
  assign out_ch.dropped_count   = oent_r.drp;
  assign out_ch.reordered_count = oent_r.ord;
  assign out_ch.last_message    = oent_r.msg;
  assign out_ch.last_of_run     = olast_r;

`include "flow_segment_stats_table_unit_assert.svh"

  `FSST_ASSERT_IMP(a_tot_range, 1'b1, tot_r <= FullCnt, "entry total beyond table")
  `FSST_ASSERT_IMP(a_no_acc_busy, st_r != ST_IDLE, !in_ch.ready, "accept while busy")
  `FSST_ASSERT_NXT(a_full_last, st_r == ST_SEG && !any_hit && tot_r == FullCnt,
    out_ch.valid && out_ch.last_of_run, "full result missing")
endmodule

[src/fsst_cell.sv]
// One table slot. A segment event matches by flow; a tick walk rotates the
// row by one place towards slot 0, the head slot being read out and
// re-entering at the tail (or dropped).
module fsst_cell (
  input  logic               clk,
  input  fsst_pkg::cell_cmd_t cmd,
  input  logic               sel_app,   // this cell is the append slot
  input  logic               live,      // slot below entry total
  input  fsst_pkg::entry_t   from_nb,   // neighbour value for the walk
  output logic               hit,
  output fsst_pkg::entry_t   q
);
  import fsst_pkg::*;

  entry_t e_r, e_nxt, base;

  assign hit = live && (e_r.flow == cmd.flow);
  assign q   = e_r;

  always_comb begin
    base  = sel_app ? '{flow: cmd.flow, default: '0} : e_r;
    e_nxt = e_r;
    if (cmd.tick) begin
      e_nxt = from_nb;
    end else if (cmd.seg && (hit || (cmd.app && sel_app))) begin
      e_nxt = base;
      if (cmd.recv) begin
        e_nxt.rcv = base.rcv + 32'd1;
        if (cmd.msg < base.msg) e_nxt.ord = base.ord + 32'd1;
        else                    e_nxt.msg = cmd.msg;
      end else begin
        e_nxt.drp = base.drp + 32'd1;
        e_nxt.msg = cmd.msg;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end
endmodule

[sim/flow_segment_stats_table_unit_tb.sv]
module flow_segment_stats_table_unit_tb;
  import fsst_pkg::*;

  localparam int unsigned SLOTS      = DefEntries;
  localparam int unsigned DRAIN_WAIT = 2 * SLOTS + 10;
  localparam int unsigned CYCLE_CAP  = 600000;

  typedef struct {
    logic        kind;
    logic [31:0] flow;
    logic [31:0] rcv;
    logic [31:0] drp;
    logic [31:0] ord;
    logic [31:0] msg;
    logic        last;
  } report_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] flow;
    logic [31:0] msg;
    bit          typed;
    report_t     want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  fsst_in_if  in_ch ();
  fsst_out_if out_ch ();

  flow_segment_stats_table_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // Shadow copy of the flow table
  logic [31:0] tbl_flow [SLOTS];
  logic [31:0] tbl_rcv  [SLOTS];
  logic [31:0] tbl_drp  [SLOTS];
  logic [31:0] tbl_ord  [SLOTS];
  logic [31:0] tbl_msg  [SLOTS];
  logic [7:0]  tbl_idle [SLOTS];
  int unsigned tbl_used;
  logic [7:0]  shadow_ttl;

  report_t     pending_reports [$];
  int unsigned mismatches;
  int unsigned reports_seen;
  int unsigned full_seen;
  int unsigned requests_sent;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic [31:0] flow_pool [24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // Table update for one accepted request; returns the reports it causes
  task automatic table_apply(input logic [1:0] func, input logic [31:0] flow,
                             input logic [31:0] msg, output report_t outs [$]);
    int unsigned rd, wr, i;
    bit          live;
    logic [7:0]  idle;
    report_t     r;
    outs = {};
    if (func == FUNC_TICK) begin
      wr = 0;
      for (rd = 0; rd < tbl_used; rd++) begin
        live = (tbl_rcv[rd] != 0) || (tbl_drp[rd] != 0) || (tbl_ord[rd] != 0) ||
               (tbl_msg[rd] != 0);
        idle = tbl_idle[rd];
        if (!live && idle == shadow_ttl) continue;
        r = '{KIND_REPORT, tbl_flow[rd], tbl_rcv[rd], tbl_drp[rd], tbl_ord[rd],
              tbl_msg[rd], 1'b0};
        outs.push_back(r);
        tbl_flow[wr] = tbl_flow[rd];
        tbl_rcv[wr]  = '0;
        tbl_drp[wr]  = '0;
        tbl_ord[wr]  = '0;
        tbl_msg[wr]  = '0;
        tbl_idle[wr] = live ? 8'd0 : idle + 8'd1;
        wr++;
      end
      tbl_used = wr;
    end else if (func == FUNC_RECV || func == FUNC_DROP) begin
      for (i = 0; i < tbl_used; i++)
        if (tbl_flow[i] == flow) break;
      if (i == tbl_used) begin
        if (tbl_used >= SLOTS) begin
          r = '{KIND_FULL, flow, '0, '0, '0, '0, 1'b0};
          outs.push_back(r);
        end else begin
          tbl_flow[i] = flow;
          tbl_rcv[i]  = '0;
          tbl_drp[i]  = '0;
          tbl_ord[i]  = '0;
          tbl_msg[i]  = '0;
          tbl_idle[i] = '0;
          tbl_used++;
        end
      end
      if (i < SLOTS) begin
        if (func == FUNC_RECV) begin
          tbl_rcv[i]++;
          if (msg < tbl_msg[i]) tbl_ord[i]++;
          else tbl_msg[i] = msg;
        end else begin
          tbl_drp[i]++;
          tbl_msg[i] = msg;
        end
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
  endtask

  // Offer one request, idling first at random; valid drops only while idling
  task automatic send_request(input logic [1:0] func, input logic [31:0] flow,
                              input logic [31:0] msg, input bit typed,
                              input report_t want);
    report_t outs [$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.flow_id    <= flow;
    in_ch.message_id <= msg;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    table_apply(func, flow, msg, outs);
    if (typed) pending_reports.push_back(want);
    else foreach (outs[k]) pending_reports.push_back(outs[k]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_ttl = v;
  endtask

  // Result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    report_t w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected report_flow", out_ch.report_flow, 32'h0);
        end else begin
          w = pending_reports.pop_front();
          if (out_ch.kind != w.kind)
            report_mismatch("kind", 32'(out_ch.kind), 32'(w.kind));
          if (out_ch.report_flow != w.flow)
            report_mismatch("report_flow", out_ch.report_flow, w.flow);
          if (out_ch.received_count != w.rcv)
            report_mismatch("received_count", out_ch.received_count, w.rcv);
          if (out_ch.dropped_count != w.drp)
            report_mismatch("dropped_count", out_ch.dropped_count, w.drp);
          if (out_ch.reordered_count != w.ord)
            report_mismatch("reordered_count", out_ch.reordered_count, w.ord);
          if (out_ch.last_message != w.msg)
            report_mismatch("last_message", out_ch.last_message, w.msg);
          if (out_ch.last_of_run != w.last)
            report_mismatch("last_of_run", 32'(out_ch.last_of_run), 32'(w.last));
          if (w.kind == KIND_FULL) full_seen++;
          else reports_seen++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Random traffic over a pool of flows large enough to overflow the table
  task automatic random_phase(input int unsigned n, input bit hold_once);
    int unsigned j, pick;
    logic [1:0]  func;
    logic [31:0] flow, msg;
    report_t     none;
    none = '{default: '0};
    for (j = 0; j < n; j++) begin
      if (hold_once && j == n / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 9) func = FUNC_TICK;
      else if (pick < 11) func = FUNC_UNUSED;
      else if (pick < 35) func = FUNC_DROP;
      else func = FUNC_RECV;
      flow = ($urandom_range(9) == 0) ? $urandom() : flow_pool[$urandom_range(23)];
      case ($urandom_range(3))
        0: msg = $urandom();
        1: msg = $urandom_range(15);
        2: msg = 32'hFFFF_FFF0 | $urandom_range(15);
        default: msg = 32'h0001_0000 + $urandom_range(255);
      endcase
      send_request(func, flow, msg, 1'b0, none);
    end
  endtask

  stim_row_t directed [$];

  initial begin
    stim_row_t row;
    report_t   none;
    none = '{default: '0};
    requests_sent = 0;
    tbl_used      = 0;
    shadow_ttl    = DefIdleTtl;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_RECV;
    in_ch.flow_id    = '0;
    in_ch.message_id = '0;
    out_ch.ready     = 1'b0;
    foreach (flow_pool[k]) flow_pool[k] = $urandom();

    // Directed rows: empty tick, extremes, reorder, drop, unused func, overflow
    directed.push_back('{FUNC_TICK, 32'h0, 32'h0, 1'b0, none});
    directed.push_back('{FUNC_RECV, 32'h0, 32'h0, 1'b0, none});
    directed.push_back('{FUNC_TICK, 32'h0, 32'h0, 1'b1,
                         '{KIND_REPORT, 32'h0, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1}});
    directed.push_back('{FUNC_RECV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none});
    directed.push_back('{FUNC_RECV, 32'hFFFF_FFFF, 32'h0, 1'b0, none});
    directed.push_back('{FUNC_DROP, 32'hFFFF_FFFF, 32'h5, 1'b0, none});
    directed.push_back('{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none});
    directed.push_back('{FUNC_TICK, 32'h0, 32'h0, 1'b0, none});
    for (int k = 1; k <= 14; k++) begin
      row = '{FUNC_DROP, 32'hA5A5_0000 + k, 32'h0, 1'b0, none};
      directed.push_back(row);
    end
    directed.push_back('{FUNC_RECV, 32'd100, 32'h7, 1'b1,
                         '{KIND_FULL, 32'd100, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1}});
    directed.push_back('{FUNC_TICK, 32'h0, 32'h0, 1'b0, none});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k])
      send_request(directed[k].func, directed[k].flow, directed[k].msg,
                   directed[k].typed, directed[k].want);
    wait_drained();

    // Phases of idling, each under a different idle lifetime
    write_ttl(8'd0);
    random_phase(100, 1'b1);
    wait_drained();
    write_ttl(8'd255);
    send_idle_pct = 54;
    random_phase(100, 1'b0);
    wait_drained();
    write_ttl(8'd1);
    send_idle_pct = 0;
    stall_pct     = 54;
    random_phase(100, 1'b0);
    wait_drained();
    write_ttl(8'($urandom_range(2, 6)));
    send_idle_pct = 31;
    stall_pct     = 31;
    random_phase(100, 1'b0);
    wait_drained();

    $display("covered %0d requests: %0d flow reports, %0d table-full events,",
             requests_sent, reports_seen, full_seen);
    $display("idle lifetimes 0, 255, 1 and random, with sender gaps and sink stalls");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
